// ----- rtl/core/spoc_pkg.sv -----
// ----------------------------------------------------------------------------
// spoc_pkg
// Shared constants, codes and controller/datapath interface types for the
// separating-axis polygon overlap checker.
// ----------------------------------------------------------------------------
package spoc_pkg;

   localparam int MAX_VERTS = 16;
   localparam int IDX_W     = $clog2(MAX_VERTS);
   localparam int CNT_W     = $clog2(MAX_VERTS + 1);
   localparam int COORD_W   = 32;
   localparam int UNIT_BITS = 30;
   localparam int STEP_W    = 5;

   localparam logic [32:0] OVL_ONES = {33{1'b1}};

   localparam logic [2:0] REQ_VERT_A   = 3'd0;
   localparam logic [2:0] REQ_VERT_B   = 3'd1;
   localparam logic [2:0] REQ_CENTRE_A = 3'd2;
   localparam logic [2:0] REQ_CENTRE_B = 3'd3;
   localparam logic [2:0] REQ_RUN      = 3'd4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FEW  = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   localparam logic [STEP_W-1:0] SQRT_LAST = 5'd31;
   localparam logic [STEP_W-1:0] DIV_LAST  = 5'd30;

   typedef enum logic [5:0] {
      S_IDLE, S_CHECK, S_RD_I, S_RD_J, S_EDGE, S_NORM,
      S_SQA, S_SQB, S_SQC, S_SQI, S_SQS,
      S_DAI, S_DAS, S_DAW, S_DBI, S_DBS, S_DBW,
      S_P_RD, S_P_MX, S_P_MY, S_P_ACC, S_P_MM, S_P_CMP, S_NEXT,
      S_SCX, S_SCXA, S_SCXS, S_SCY, S_SCYA, S_SCYS,
      S_DX, S_DY, S_DACC, S_DNEG, S_FINISH
   } state_type;

   typedef enum logic [1:0] {NORM_NONE, NORM_HALVE, NORM_DBL} norm_op_type;

   typedef enum logic [3:0] {
      MUL_NONE, MUL_SQA, MUL_SQB, MUL_PX, MUL_PY, MUL_SCX, MUL_SCY, MUL_DX, MUL_DY
   } mul_sel_type;

   typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_HI} acc_op_type;

   typedef enum logic [1:0] {OUT_STATUS, OUT_APART, OUT_HIT} out_kind_type;

   typedef struct packed {
      logic              load;
      logic              run_clear;
      logic              rd_en;
      logic              rd_shape;
      logic [IDX_W-1:0]  rd_addr;
      logic              lat_vi;
      logic              edge_ld;
      norm_op_type       norm_op;
      mul_sel_type       mul_sel;
      acc_op_type        acc_op;
      logic              comp_y;
      logic              sq_init;
      logic              sq_step;
      logic              div_init;
      logic              div_step;
      logic              div_b;
      logic              div_store;
      logic              mm_en;
      logic              mm_shape;
      logic              mm_first;
      logic              best_init;
      logic              ovl_en;
      logic              push_store;
      logic              neg_store;
      logic              out_load;
      out_kind_type      out_kind;
      logic [1:0]        out_status;
   } dp_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0]  count_a;
      logic [CNT_W-1:0]  count_b;
      logic              overflow;
      logic              m_zero;
      logic              m_big;
      logic              m_small;
      logic              sep;
   } dp_stat_type;

endpackage

// ----- rtl/core/sat_polygon_overlap_check_top.sv -----
// ----------------------------------------------------------------------------
// sat_polygon_overlap_check_top
// Separating-axis overlap test for two convex polygons in signed Q16.16.
// ----------------------------------------------------------------------------
// A transaction is accepted on a rising edge with start high and busy low.
// Vertex and centre loads are taken while idle and produce no result; busy stays
// low. A run transaction raises busy until its single result has been
// formed, and the result then appears on the rsp_ ports for exactly one
// cycle with rsp_valid high. The receiver cannot stall, so it must capture
// the result in that cycle. The run length is set by the controller's
// per-axis sequence, which shares one multiplier, a one-bit-per-cycle square
// root and a one-bit-per-cycle divider. Each edge vector is halved once when
// large or doubled until normalized when small, a zero-length edge is skipped,
// and the vertices of both shapes are projected onto each axis. A run stops
// early at the first separating axis, goes straight to the result when a
// status error is reported, and otherwise ends by forming the push vector.
// Every run clears both vertex counts and the overflow flag; the centres are
// kept.
// ----------------------------------------------------------------------------
module sat_polygon_overlap_check_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_type,
   input  logic signed [31:0]  req_coord_x,
   input  logic signed [31:0]  req_coord_y,
   output logic                rsp_valid,
   output logic                rsp_collides,
   output logic [31:0]         rsp_overlap_depth,
   output logic signed [31:0]  rsp_push_x,
   output logic signed [31:0]  rsp_push_y,
   output logic [1:0]          rsp_status
);
   import spoc_pkg::*;

   // Commands flow from the controller; counts and comparison flags return.
   dp_cmd_type  cmd;
   dp_stat_type stat;

   spoc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   spoc_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_type          (req_type),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_collides      (rsp_collides),
      .rsp_overlap_depth (rsp_overlap_depth),
      .rsp_push_x        (rsp_push_x),
      .rsp_push_y        (rsp_push_y),
      .rsp_status        (rsp_status)
   );

endmodule

// ----- rtl/core/spoc_dp.sv -----
// ----------------------------------------------------------------------------
// spoc_dp
// Datapath: vertex stores, shared multiplier and accumulator, iterative square
// root and divider, projection bounds, kept overlap and result registers.
// ----------------------------------------------------------------------------
module spoc_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  spoc_pkg::dp_cmd_type     cmd,
   input  logic [2:0]               req_type,
   input  logic signed [31:0]       req_coord_x,
   input  logic signed [31:0]       req_coord_y,
   output spoc_pkg::dp_stat_type    stat,
   output logic                     rsp_valid,
   output logic                     rsp_collides,
   output logic [31:0]              rsp_overlap_depth,
   output logic signed [31:0]       rsp_push_x,
   output logic signed [31:0]       rsp_push_y,
   output logic [1:0]               rsp_status
);
   import spoc_pkg::*;

   logic [63:0] mem_a [MAX_VERTS];
   logic [63:0] mem_b [MAX_VERTS];

   logic [CNT_W-1:0] count_a_ff, count_a_in, count_b_ff, count_b_in;
   logic             ovf_ff, ovf_in;
   logic signed [31:0] ca_x_ff, ca_y_ff, cb_x_ff, cb_y_ff;

   logic [63:0] rdata_ff, vi_ff;
   logic [32:0] na_ff, nb_ff;
   logic        sx_ff, sy_ff;
   logic signed [66:0] prod_ff, acc_ff;
   logic [63:0] sq_x_ff, sq_res_ff, sq_bit_ff;
   logic [33:0] rem_ff;
   logic [30:0] q_ff;
   logic signed [31:0] ux_ff, uy_ff, kux_ff, kuy_ff;
   logic signed [64:0] mn1_ff, mx1_ff, mn2_ff, mx2_ff;
   logic [32:0] best_ff;
   logic signed [35:0] px_ff, py_ff;
   logic        neg_ff;
   logic        valid_ff;
   logic        coll_ff;
   logic [31:0] depth_ff;
   logic signed [31:0] pushx_ff, pushy_ff;
   logic [1:0]  status_ff;

   // ---- combinational helpers
   logic signed [33:0] nx, ny;
   logic signed [33:0] op1;
   logic signed [32:0] op2;
   logic [30:0] kabs_x, kabs_y, kabs;
   logic signed [32:0] dx, dy;
   logic [63:0] sq_t;
   logic        div_ge;
   logic [33:0] div_r;
   logic signed [31:0] u_new;
   logic signed [64:0] proj;
   logic signed [65:0] d0, d1, dmin;
   logic [35:0] ov36;
   logic [32:0] ov33;
   logic [33:0] pmag;
   logic signed [35:0] pval;
   logic signed [35:0] fx, fy;

   function automatic logic [31:0] sat32(input logic signed [35:0] v);
      if (v > 36'sd2147483647) begin
         return 32'h7FFF_FFFF;
      end else if (v < -36'sd2147483648) begin
         return 32'h8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

   always_comb begin
      nx = {{2{vi_ff[31]}}, vi_ff[31:0]} - {{2{rdata_ff[31]}}, rdata_ff[31:0]};
      ny = {{2{rdata_ff[63]}}, rdata_ff[63:32]} - {{2{vi_ff[63]}}, vi_ff[63:32]};
      kabs_x = kux_ff[31] ? 31'(-kux_ff) : kux_ff[30:0];
      kabs_y = kuy_ff[31] ? 31'(-kuy_ff) : kuy_ff[30:0];
      kabs   = cmd.comp_y ? kabs_y : kabs_x;
      dx = {cb_x_ff[31], cb_x_ff} - {ca_x_ff[31], ca_x_ff};
      dy = {cb_y_ff[31], cb_y_ff} - {ca_y_ff[31], ca_y_ff};
      op1 = '0;
      op2 = '0;
      case (cmd.mul_sel)
         MUL_SQA: begin
            op1 = {2'b0, na_ff[31:0]};
            op2 = {1'b0, na_ff[31:0]};
         end
         MUL_SQB: begin
            op1 = {2'b0, nb_ff[31:0]};
            op2 = {1'b0, nb_ff[31:0]};
         end
         MUL_PX: begin
            op1 = {{2{rdata_ff[63]}}, rdata_ff[63:32]};
            op2 = {ux_ff[31], ux_ff};
         end
         MUL_PY: begin
            op1 = {{2{rdata_ff[31]}}, rdata_ff[31:0]};
            op2 = {uy_ff[31], uy_ff};
         end
         MUL_SCX: begin
            op1 = {3'b0, kabs_x};
            op2 = {1'b0, best_ff[31:0]};
         end
         MUL_SCY: begin
            op1 = {3'b0, kabs_y};
            op2 = {1'b0, best_ff[31:0]};
         end
         MUL_DX: begin
            op1 = {dx[32], dx};
            op2 = {kux_ff[31], kux_ff};
         end
         MUL_DY: begin
            op1 = {dy[32], dy};
            op2 = {kuy_ff[31], kuy_ff};
         end
         default: begin
         end
      endcase
      sq_t   = sq_res_ff + sq_bit_ff;
      div_ge = rem_ff >= {2'b0, sq_res_ff[31:0]};
      div_r  = div_ge ? rem_ff - {2'b0, sq_res_ff[31:0]} : rem_ff;
      u_new  = (cmd.div_b ? sy_ff : sx_ff) ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
      proj   = acc_ff[64:0];
      d0     = {mx1_ff[64], mx1_ff} - {mn2_ff[64], mn2_ff};
      d1     = {mx2_ff[64], mx2_ff} - {mn1_ff[64], mn1_ff};
      dmin   = (d0 < d1) ? d0 : d1;
      ov36   = dmin[65:30];
      ov33   = (ov36[35:33] != 3'b0) ? OVL_ONES : ov36[32:0];
      pmag   = acc_ff[63:30];
      pval   = (cmd.comp_y ? kuy_ff[31] : kux_ff[31]) ? -$signed({2'b0, pmag})
                                                      : $signed({2'b0, pmag});
      fx     = neg_ff ? -px_ff : px_ff;
      fy     = neg_ff ? -py_ff : py_ff;
   end

   // ---- load path
   always_comb begin
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      ovf_in     = ovf_ff;
      if (cmd.load) begin
         case (req_type)
            REQ_VERT_A: begin
               if (count_a_ff < CNT_W'(MAX_VERTS)) count_a_in = count_a_ff + 1'b1;
               else ovf_in = 1'b1;
            end
            REQ_VERT_B: begin
               if (count_b_ff < CNT_W'(MAX_VERTS)) count_b_in = count_b_ff + 1'b1;
               else ovf_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
      if (cmd.run_clear) begin
         count_a_in = '0;
         count_b_in = '0;
         ovf_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff <= '0;
         count_b_ff <= '0;
         ovf_ff     <= 1'b0;
         ca_x_ff    <= '0;
         ca_y_ff    <= '0;
         cb_x_ff    <= '0;
         cb_y_ff    <= '0;
         valid_ff   <= 1'b0;
      end else begin
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
         ovf_ff     <= ovf_in;
         valid_ff   <= cmd.out_load;
         if (cmd.load && req_type == REQ_CENTRE_A) begin
            ca_x_ff <= req_coord_x;
            ca_y_ff <= req_coord_y;
         end
         if (cmd.load && req_type == REQ_CENTRE_B) begin
            cb_x_ff <= req_coord_x;
            cb_y_ff <= req_coord_y;
         end
      end
   end

   // ---- vertex stores
   always_ff @(posedge clock) begin
      if (cmd.load && req_type == REQ_VERT_A && count_a_ff < CNT_W'(MAX_VERTS)) begin
         mem_a[count_a_ff[IDX_W-1:0]] <= {req_coord_x, req_coord_y};
      end
      if (cmd.load && req_type == REQ_VERT_B && count_b_ff < CNT_W'(MAX_VERTS)) begin
         mem_b[count_b_ff[IDX_W-1:0]] <= {req_coord_x, req_coord_y};
      end
      if (cmd.rd_en) begin
         rdata_ff <= cmd.rd_shape ? mem_b[cmd.rd_addr] : mem_a[cmd.rd_addr];
      end
   end

   // ---- arithmetic datapath
   always_ff @(posedge clock) begin
      if (cmd.lat_vi) vi_ff <= rdata_ff;
      if (cmd.edge_ld) begin
         na_ff <= nx[33] ? 33'(-nx) : nx[32:0];
         nb_ff <= ny[33] ? 33'(-ny) : ny[32:0];
         sx_ff <= nx[33];
         sy_ff <= ny[33];
      end
      case (cmd.norm_op)
         NORM_HALVE: begin
            na_ff <= na_ff >> 1;
            nb_ff <= nb_ff >> 1;
         end
         NORM_DBL: begin
            na_ff <= na_ff << 1;
            nb_ff <= nb_ff << 1;
         end
         default: begin
         end
      endcase
      if (cmd.mul_sel != MUL_NONE) prod_ff <= op1 * op2;
      case (cmd.acc_op)
         ACC_LOAD: acc_ff <= prod_ff;
         ACC_ADD:  acc_ff <= acc_ff + prod_ff;
         ACC_HI:   acc_ff <= prod_ff + (best_ff[32] ? {4'b0, kabs, 32'b0} : 67'sd0);
         default: begin
         end
      endcase
      if (cmd.sq_init) begin
         sq_x_ff   <= acc_ff[63:0];
         sq_res_ff <= '0;
         sq_bit_ff <= 64'h4000_0000_0000_0000;
      end else if (cmd.sq_step) begin
         if (sq_x_ff >= sq_t) begin
            sq_x_ff   <= sq_x_ff - sq_t;
            sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
         end else begin
            sq_res_ff <= sq_res_ff >> 1;
         end
         sq_bit_ff <= sq_bit_ff >> 2;
      end
      if (cmd.div_init) begin
         rem_ff <= {1'b0, cmd.div_b ? nb_ff : na_ff};
         q_ff   <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= {div_r[32:0], 1'b0};
         q_ff   <= {q_ff[29:0], div_ge};
      end
      if (cmd.div_store) begin
         if (cmd.div_b) uy_ff <= u_new;
         else ux_ff <= u_new;
      end
      if (cmd.mm_en) begin
         if (cmd.mm_shape) begin
            if (cmd.mm_first || proj < mn2_ff) mn2_ff <= proj;
            if (cmd.mm_first || proj > mx2_ff) mx2_ff <= proj;
         end else begin
            if (cmd.mm_first || proj < mn1_ff) mn1_ff <= proj;
            if (cmd.mm_first || proj > mx1_ff) mx1_ff <= proj;
         end
      end
      if (cmd.best_init) begin
         best_ff <= OVL_ONES;
         kux_ff  <= '0;
         kuy_ff  <= '0;
      end else if (cmd.ovl_en && ov33 < best_ff) begin
         best_ff <= ov33;
         kux_ff  <= ux_ff;
         kuy_ff  <= uy_ff;
      end
      if (cmd.push_store) begin
         if (cmd.comp_y) py_ff <= pval;
         else px_ff <= pval;
      end
      if (cmd.neg_store) neg_ff <= acc_ff > 67'sd0;
      if (cmd.out_load) begin
         status_ff <= cmd.out_status;
         coll_ff   <= 1'b0;
         depth_ff  <= '0;
         pushx_ff  <= '0;
         pushy_ff  <= '0;
         if (cmd.out_kind == OUT_HIT) begin
            coll_ff  <= 1'b1;
            depth_ff <= best_ff[32] ? 32'hFFFF_FFFF : best_ff[31:0];
            pushx_ff <= sat32(fx);
            pushy_ff <= sat32(fy);
         end
      end
   end

   always_comb begin
      stat.count_a  = count_a_ff;
      stat.count_b  = count_b_ff;
      stat.overflow = ovf_ff;
      stat.m_zero   = (na_ff == '0) && (nb_ff == '0);
      stat.m_big    = (na_ff[32:31] != 2'b0) || (nb_ff[32:31] != 2'b0);
      stat.m_small  = (na_ff[32:30] == 3'b0) && (nb_ff[32:30] == 3'b0);
      stat.sep      = (mn2_ff > mx1_ff) || (mn1_ff > mx2_ff);
   end

   assign rsp_valid         = valid_ff;
   assign rsp_collides      = coll_ff;
   assign rsp_overlap_depth = depth_ff;
   assign rsp_push_x        = pushx_ff;
   assign rsp_push_y        = pushy_ff;
   assign rsp_status        = status_ff;

endmodule

// ----- rtl/core/spoc_ctrl.sv -----
// ----------------------------------------------------------------------------
// spoc_ctrl
// Controller: walks the edges of both shapes, sequences the axis unit, the
// projections and the final push vector, and issues datapath commands.
// ----------------------------------------------------------------------------
module spoc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [2:0]               req_type,
   input  spoc_pkg::dp_stat_type    stat,
   output spoc_pkg::dp_cmd_type     cmd,
   output logic                     busy
);
   import spoc_pkg::*;

   state_type           state_ff, state_in;
   logic                shape_ff, shape_in;
   logic                pshape_ff, pshape_in;
   logic [IDX_W-1:0]    i_ff, i_in, k_ff, k_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   out_kind_type        kind_ff, kind_in;
   logic [1:0]          status_ff, status_in;

   logic [CNT_W-1:0]    n_edge, n_proj, i_next, k_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         shape_ff  <= 1'b0;
         pshape_ff <= 1'b0;
         i_ff      <= '0;
         k_ff      <= '0;
         cnt_ff    <= '0;
         kind_ff   <= OUT_STATUS;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         shape_ff  <= shape_in;
         pshape_ff <= pshape_in;
         i_ff      <= i_in;
         k_ff      <= k_in;
         cnt_ff    <= cnt_in;
         kind_ff   <= kind_in;
         status_ff <= status_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      shape_in  = shape_ff;
      pshape_in = pshape_ff;
      i_in      = i_ff;
      k_in      = k_ff;
      cnt_in    = cnt_ff;
      kind_in   = kind_ff;
      status_in = status_ff;
      cmd          = '0;
      cmd.norm_op  = NORM_NONE;
      cmd.mul_sel  = MUL_NONE;
      cmd.acc_op   = ACC_HOLD;
      cmd.out_kind = kind_ff;
      cmd.out_status = status_ff;
      n_edge = shape_ff ? stat.count_b : stat.count_a;
      n_proj = pshape_ff ? stat.count_b : stat.count_a;
      i_next = {1'b0, i_ff} + 1'b1;
      k_next = {1'b0, k_ff} + 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_type == REQ_RUN) state_in = S_CHECK;
               else cmd.load = 1'b1;
            end
         end
         S_CHECK: begin
            if (stat.overflow) begin
               kind_in   = OUT_STATUS;
               status_in = ST_OVF;
               state_in  = S_FINISH;
            end else if (stat.count_a < CNT_W'(3) || stat.count_b < CNT_W'(3)) begin
               kind_in   = OUT_STATUS;
               status_in = ST_FEW;
               state_in  = S_FINISH;
            end else begin
               cmd.best_init = 1'b1;
               shape_in  = 1'b0;
               i_in      = '0;
               status_in = ST_OK;
               state_in  = S_RD_I;
            end
         end
         S_RD_I: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_shape = shape_ff;
            cmd.rd_addr  = i_ff;
            state_in     = S_RD_J;
         end
         S_RD_J: begin
            cmd.lat_vi   = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.rd_shape = shape_ff;
            cmd.rd_addr  = (i_next == n_edge) ? '0 : i_next[IDX_W-1:0];
            state_in     = S_EDGE;
         end
         S_EDGE: begin
            cmd.edge_ld = 1'b1;
            state_in    = S_NORM;
         end
         S_NORM: begin
            // A degenerate edge gives no axis.
            if (stat.m_zero) begin
               state_in = S_NEXT;
            end else if (stat.m_big) begin
               cmd.norm_op = NORM_HALVE;
               state_in    = S_SQA;
            end else if (stat.m_small) begin
               cmd.norm_op = NORM_DBL;
            end else begin
               state_in = S_SQA;
            end
         end
         S_SQA: begin
            cmd.mul_sel = MUL_SQA;
            state_in    = S_SQB;
         end
         S_SQB: begin
            cmd.mul_sel = MUL_SQB;
            cmd.acc_op  = ACC_LOAD;
            state_in    = S_SQC;
         end
         S_SQC: begin
            cmd.acc_op = ACC_ADD;
            state_in   = S_SQI;
         end
         S_SQI: begin
            cmd.sq_init = 1'b1;
            cnt_in      = '0;
            state_in    = S_SQS;
         end
         S_SQS: begin
            cmd.sq_step = 1'b1;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == SQRT_LAST) state_in = S_DAI;
         end
         S_DAI: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = S_DAS;
         end
         S_DAS: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = S_DAW;
         end
         S_DAW: begin
            cmd.div_store = 1'b1;
            state_in      = S_DBI;
         end
         S_DBI: begin
            cmd.div_init = 1'b1;
            cmd.div_b    = 1'b1;
            cnt_in       = '0;
            state_in     = S_DBS;
         end
         S_DBS: begin
            cmd.div_step = 1'b1;
            cmd.div_b    = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = S_DBW;
         end
         S_DBW: begin
            cmd.div_store = 1'b1;
            cmd.div_b     = 1'b1;
            pshape_in     = 1'b0;
            k_in          = '0;
            state_in      = S_P_RD;
         end
         S_P_RD: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_shape = pshape_ff;
            cmd.rd_addr  = k_ff;
            state_in     = S_P_MX;
         end
         S_P_MX: begin
            cmd.mul_sel = MUL_PX;
            state_in    = S_P_MY;
         end
         S_P_MY: begin
            cmd.mul_sel = MUL_PY;
            cmd.acc_op  = ACC_LOAD;
            state_in    = S_P_ACC;
         end
         S_P_ACC: begin
            cmd.acc_op = ACC_ADD;
            state_in   = S_P_MM;
         end
         S_P_MM: begin
            cmd.mm_en    = 1'b1;
            cmd.mm_shape = pshape_ff;
            cmd.mm_first = (k_ff == '0);
            if (k_next == n_proj) begin
               k_in = '0;
               if (!pshape_ff) begin
                  pshape_in = 1'b1;
                  state_in  = S_P_RD;
               end else begin
                  state_in = S_P_CMP;
               end
            end else begin
               k_in     = k_next[IDX_W-1:0];
               state_in = S_P_RD;
            end
         end
         S_P_CMP: begin
            if (stat.sep) begin
               kind_in  = OUT_APART;
               state_in = S_FINISH;
            end else begin
               cmd.ovl_en = 1'b1;
               state_in   = S_NEXT;
            end
         end
         S_NEXT: begin
            if (i_next == n_edge) begin
               i_in = '0;
               if (!shape_ff) begin
                  shape_in = 1'b1;
                  state_in = S_RD_I;
               end else begin
                  state_in = S_SCX;
               end
            end else begin
               i_in     = i_next[IDX_W-1:0];
               state_in = S_RD_I;
            end
         end
         S_SCX: begin
            cmd.mul_sel = MUL_SCX;
            state_in    = S_SCXA;
         end
         S_SCXA: begin
            cmd.acc_op = ACC_HI;
            state_in   = S_SCXS;
         end
         S_SCXS: begin
            cmd.push_store = 1'b1;
            state_in       = S_SCY;
         end
         S_SCY: begin
            cmd.mul_sel = MUL_SCY;
            state_in    = S_SCYA;
         end
         S_SCYA: begin
            cmd.acc_op = ACC_HI;
            cmd.comp_y = 1'b1;
            state_in   = S_SCYS;
         end
         S_SCYS: begin
            cmd.push_store = 1'b1;
            cmd.comp_y     = 1'b1;
            state_in       = S_DX;
         end
         S_DX: begin
            cmd.mul_sel = MUL_DX;
            state_in    = S_DY;
         end
         S_DY: begin
            cmd.mul_sel = MUL_DY;
            cmd.acc_op  = ACC_LOAD;
            state_in    = S_DACC;
         end
         S_DACC: begin
            cmd.acc_op = ACC_ADD;
            state_in   = S_DNEG;
         end
         S_DNEG: begin
            cmd.neg_store = 1'b1;
            kind_in       = OUT_HIT;
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            cmd.out_load  = 1'b1;
            cmd.run_clear = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule
